>>> sv/kbsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbsd_pkg
// Types and constants for the keyboard status/data register block.
// ----------------------------------------------------------------------------
package kbsd_pkg;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_READ   = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_STATUS_ADDR = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DATA_ADDR   = 2'd1;

  localparam logic [15:0] STATUS_ADDR_RST = 16'hFE00;
  localparam logic [15:0] DATA_ADDR_RST   = 16'hFE02;

  localparam int unsigned READY_BIT = 15;
  localparam int unsigned IE_BIT    = 14;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] address;
    logic [15:0] write_data;
    logic        key_valid;
    logic [7:0]  key_char;
  } req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        irq;
    logic        key_dropped;
  } rsp_t;

  typedef struct packed {
    logic       raised;
    logic [7:0] char_code;
  } key_entry_t;

endpackage

>>> sv/keyboard_status_data_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_status_data_fifo
// Keyboard status and data registers in front of a key FIFO held in a
// synchronous single-port-write memory.
//
//   channel | handshake               | payload
//   --------+-------------------------+--------------------------
//   request | start_i, busy_o         | req_i  (kbsd_pkg::req_t)
//   result  | rsp_valid_o (strobe)    | rsp_o  (kbsd_pkg::rsp_t)
//   config  | cfg_valid_i, cfg_ready_o| cfg_index_i, cfg_wdata_i
//
// Reads, writes and unused commands: result strobed in the cycle after the
// transfer; busy_o stays low, so a new request may follow in the next cycle.
// Ticks: the head entry is read from the key memory on the transfer, then
// marked raised and written back if not yet raised and ie is set (busy_o
// high for one cycle); the result is strobed in the cycle after. A new key
// pushed into an empty FIFO is forwarded around the memory read.
// Reset clears all control state; the key memory is not cleared.
// The result side cannot stall; cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module keyboard_status_data_fifo #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  kbsd_pkg::req_t                 req_i,
  output logic                           rsp_valid_o,
  output kbsd_pkg::rsp_t                 rsp_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [kbsd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [15:0]                    cfg_wdata_i
);

  localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(FIFO_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_TICK = 1'b1;

  logic                 state_q, state_d;
  logic [15:0]          status_addr_q, kbdr_addr_q;
  logic                 ready_q, ready_d;
  logic                 ie_q, ie_d;
  logic [7:0]           data_q, data_d;
  logic [PtrW-1:0]      head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 fwd_q, hit_q, drop_q;
  logic [7:0]           fwd_char_q;
  logic                 rsp_valid_q, rsp_valid_d;
  kbsd_pkg::rsp_t       rsp_q, rsp_d;

  kbsd_pkg::key_entry_t mem_q [FIFO_DEPTH];
  kbsd_pkg::key_entry_t rd_q;
  kbsd_pkg::key_entry_t head_entry;
  kbsd_pkg::key_entry_t mem_wdata;
  logic [PtrW-1:0]      mem_waddr;
  logic                 mem_we;

  logic accept, cfg_wr, push, tick_acc, status_hit, data_hit;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrLast) ? '0 : p + PtrW'(1);
    return r;
  endfunction

  assign busy_o      = (state_q == ST_TICK);
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign accept      = start_i && !busy_o;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  assign status_hit = (req_i.address == status_addr_q);
  assign data_hit   = (req_i.address == kbdr_addr_q);
  assign tick_acc   = accept && (req_i.cmd == kbsd_pkg::CMD_TICK);
  assign push       = tick_acc && req_i.key_valid && (count_q < CntFull);
  assign head_entry = fwd_q ?
                      kbsd_pkg::key_entry_t'{raised: 1'b0, char_code: fwd_char_q} : rd_q;

  always_comb begin
    state_d     = state_q;
    ready_d     = ready_q;
    ie_d        = ie_q;
    data_d      = data_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    rsp_valid_d = 1'b0;
    rsp_d       = '0;
    mem_we      = 1'b0;
    mem_waddr   = tail_q;
    mem_wdata   = '{raised: 1'b0, char_code: req_i.key_char};

    if (state_q == ST_TICK) begin
      state_d     = ST_IDLE;
      rsp_valid_d = 1'b1;
      rsp_d.key_dropped = drop_q;
      if (hit_q) begin
        ready_d = 1'b1;
        data_d  = head_entry.char_code;
        if (!head_entry.raised && ie_q) begin
          mem_we    = 1'b1;
          mem_waddr = head_q;
          mem_wdata = '{raised: 1'b1, char_code: head_entry.char_code};
          rsp_d.irq = 1'b1;
        end
      end
    end else if (accept) begin
      case (req_i.cmd)
        kbsd_pkg::CMD_TICK: begin
          state_d = ST_TICK;
          if (push) begin
            mem_we  = 1'b1;
            tail_d  = next_ptr(tail_q);
            count_d = count_q + CntW'(1);
          end
        end
        kbsd_pkg::CMD_READ: begin
          rsp_valid_d = 1'b1;
          if (status_hit) begin
            rsp_d.read_data[kbsd_pkg::READY_BIT] = ready_q;
            rsp_d.read_data[kbsd_pkg::IE_BIT]    = ie_q;
          end else if (data_hit) begin
            rsp_d.read_data = {8'd0, data_q};
            if (ready_q) begin
              ready_d = 1'b0;
              if (count_q != '0) begin
                head_d  = next_ptr(head_q);
                count_d = count_q - CntW'(1);
              end
            end
          end
        end
        kbsd_pkg::CMD_WRITE: begin
          rsp_valid_d = 1'b1;
          if (status_hit) begin
            ie_d    = req_i.write_data[kbsd_pkg::IE_BIT];
            ready_d = 1'b0;
          end
        end
        default: begin
          rsp_valid_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      status_addr_q <= kbsd_pkg::STATUS_ADDR_RST;
      kbdr_addr_q   <= kbsd_pkg::DATA_ADDR_RST;
      ready_q       <= 1'b0;
      ie_q          <= 1'b0;
      data_q        <= '0;
      head_q        <= '0;
      tail_q        <= '0;
      count_q       <= '0;
      rsp_valid_q   <= 1'b0;
      fwd_q         <= 1'b0;
      hit_q         <= 1'b0;
      drop_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      ie_q        <= ie_d;
      data_q      <= data_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
      if (tick_acc) begin
        fwd_q  <= push && (count_q == '0);
        hit_q  <= (count_d != '0);
        drop_q <= req_i.key_valid && !push;
      end
      if (cfg_wr) begin
        case (cfg_index_i)
          kbsd_pkg::CFG_STATUS_ADDR: status_addr_q <= cfg_wdata_i;
          kbsd_pkg::CFG_DATA_ADDR:   kbdr_addr_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (tick_acc) begin
      fwd_char_q <= req_i.key_char;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (tick_acc) begin
      rd_q <= mem_q[head_q];
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("key count exceeds FIFO depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("empty FIFO with unequal pointers");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> busy_o && !rsp_valid_o)
    else $error("tick transfer did not enter the memory cycle");

  a_tick_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> rsp_valid_o && !busy_o)
    else $error("tick result missing after memory cycle");

  a_irq_ie: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.irq) |-> ie_q && ready_q)
    else $error("interrupt raised without enable");

endmodule
